// ===== rtl/teq_pkg.sv =====
// Timed event queue package: request and result codes and time constants.
// Used by the top level and its checker; depends on nothing.
`timescale 1ns / 1ps
package teq_pkg;

  localparam int TIME_W = 64;
  localparam logic [TIME_W-1:0] TIME_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_PROCESS  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    KIND_SCHEDULED    = 3'd0,
    KIND_CANCEL_DONE  = 3'd1,
    KIND_FIRED        = 3'd2,
    KIND_PROCESS_DONE = 3'd3,
    KIND_FULL         = 3'd4
  } kind_t;

endpackage

// ===== rtl/teq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module teq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/timed_event_queue.sv =====
// Timed event queue: sorted event store and free ID FIFO held in two RAMs.
// Steps: schedule takes a free or new ID, shifts later entries up from the tail and writes the new
// entry, or gets a full error; cancel walks every entry; process fires due entries from the head.
// One request at a time; the slot RAM read port walks one entry per cycle unless the output stalls.
// Synchronous reset empties the queue, the free FIFO and the ID counter; no clearing pass.
`timescale 1ns / 1ps
module timed_event_queue
  import teq_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int TAG_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  input  logic s_tvalid,
  output logic s_tready,
  // event_time, tag, cancel_id, now_time
  input  logic [((2*TIME_W+TAG_BITS+$clog2(CAPACITY+1)+7)/8)*8-1:0] s_tdata,
  // op
  input  logic [1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // evt_id, fired_tag, new_head, fired_count, head_time, pending_count
  output logic [((TIME_W+TAG_BITS+1+3*$clog2(CAPACITY+1)+7)/8)*8-1:0] m_tdata,
  // kind
  output logic [2:0] m_tuser,
  output logic m_tlast
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IDW = CW;
  localparam int SLOT_W = TIME_W + IDW + TAG_BITS;
  localparam int OUT_BITS = IDW + TAG_BITS + 1 + CW + TIME_W + CW;

  typedef enum logic [2:0] {
    IDLE, S_FREE, S_SCAN, S_DATA, S_FLUSH, S_WRNEW, S_EMIT
  } state_t;

  state_t state;
  op_t rq_op;
  logic [TIME_W-1:0] rq_time, rq_now, head_t;
  logic [TAG_BITS-1:0] rq_tag, pf_tag;
  logic [IDW-1:0] rq_cid, new_id, id_ctr, pf_id, res_id;
  logic [CW-1:0] total, idx, fcnt, free_fill;
  logic [AW-1:0] free_head, pos;
  logic found, pend, notify, res_nh;
  kind_t res_kind;

  kind_t out_kind;
  logic [IDW-1:0] out_id;
  logic [TAG_BITS-1:0] out_tag;
  logic out_nh, out_last;
  logic [CW-1:0] out_fc, out_pend;
  logic [TIME_W-1:0] out_head;

  logic slot_we, slot_re, free_we, free_re;
  logic [AW-1:0] slot_waddr, slot_raddr, free_waddr, free_raddr;
  logic [SLOT_W-1:0] slot_wdata, slot_rdata;
  logic [IDW-1:0] free_wdata, free_rdata;

  logic [TIME_W-1:0] rd_time;
  logic [IDW-1:0] rd_id;
  logic [TAG_BITS-1:0] rd_tag;
  logic out_free, last_idx, sched_less, cid_hit, found_now, due, proc_stall, proc_end;
  logic out_load;
  logic [CW:0] tail_sum, tail;

  teq_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .re(slot_re), .raddr(slot_raddr), .rdata(slot_rdata)
  );

  teq_ram #(.WIDTH(IDW), .DEPTH(CAPACITY)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .re(free_re), .raddr(free_raddr), .rdata(free_rdata)
  );

  assign rd_time = slot_rdata[TIME_W-1:0];
  assign rd_id   = slot_rdata[TIME_W +: IDW];
  assign rd_tag  = slot_rdata[TIME_W+IDW +: TAG_BITS];

  assign s_tready   = (state == IDLE);
  assign out_free   = !m_tvalid || m_tready;
  assign last_idx   = (idx == total - CW'(1));
  assign sched_less = $signed(rq_time) < $signed(rd_time);
  assign cid_hit    = !found && (rd_id == rq_cid);
  assign found_now  = found || cid_hit;
  assign due        = !($signed(rq_now) < $signed(rd_time));
  assign proc_stall = pend && !out_free;
  assign proc_end   = last_idx || (!due && fcnt == '0);
  assign out_load   = out_free && ((state == S_DATA && rq_op == OP_PROCESS && pend)
                                   || state == S_FLUSH || state == S_EMIT);
  assign tail_sum   = (CW+1)'(free_head) + (CW+1)'(free_fill);
  assign tail       = (tail_sum >= (CW+1)'(CAPACITY)) ? tail_sum - (CW+1)'(CAPACITY)
                                                       : tail_sum;

  always_comb begin
    slot_we = 1'b0;
    slot_waddr = '0;
    slot_wdata = slot_rdata;
    slot_re = 1'b0;
    slot_raddr = '0;
    free_we = 1'b0;
    free_wdata = rq_cid;
    free_re = 1'b0;
    free_raddr = free_head;
    free_waddr = tail[AW-1:0];
    case (state)
      IDLE: begin
        if (s_tvalid) begin
          case (op_t'(s_tuser))
            OP_SCHEDULE: free_re = (total != CW'(CAPACITY)) && (free_fill != '0);
            OP_CANCEL, OP_PROCESS: slot_re = (total != '0);
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        slot_re = (total != '0);
        slot_raddr = AW'(total - CW'(1));
      end
      S_DATA: begin
        case (rq_op)
          OP_SCHEDULE: begin
            if (sched_less) begin
              slot_we = 1'b1;
              slot_waddr = AW'(idx + CW'(1));
              slot_re = (idx != '0);
              slot_raddr = AW'(idx - CW'(1));
            end
          end
          OP_CANCEL: begin
            slot_we = found;
            slot_waddr = AW'(idx - CW'(1));
            slot_re = !last_idx;
            slot_raddr = AW'(idx + CW'(1));
            free_we = last_idx && found_now && (free_fill < CW'(CAPACITY));
          end
          OP_PROCESS: begin
            if (!proc_stall) begin
              free_we = due && (free_fill < CW'(CAPACITY));
              free_wdata = rd_id;
              slot_we = !due && (fcnt != '0);
              slot_waddr = AW'(idx - fcnt);
              slot_re = !proc_end;
              slot_raddr = AW'(idx + CW'(1));
            end
          end
          default: ;
        endcase
      end
      S_WRNEW: begin
        slot_we = 1'b1;
        slot_waddr = pos;
        slot_wdata = {rq_tag, new_id, rq_time};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      total <= '0;
      free_head <= '0;
      free_fill <= '0;
      id_ctr <= '0;
      notify <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        notify <= cfg_wdata;
      end
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      if (slot_we && slot_waddr == '0) begin
        head_t <= slot_wdata[TIME_W-1:0];
      end
      if (free_we) begin
        free_fill <= free_fill + CW'(1);
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            rq_op <= op_t'(s_tuser);
            rq_time <= s_tdata[TIME_W-1:0];
            rq_tag <= s_tdata[TIME_W +: TAG_BITS];
            rq_cid <= s_tdata[TIME_W+TAG_BITS +: IDW];
            rq_now <= s_tdata[TIME_W+TAG_BITS+IDW +: TIME_W];
            fcnt <= '0;
            found <= 1'b0;
            pend <= 1'b0;
            idx <= '0;
            res_id <= '0;
            res_nh <= 1'b0;
            case (op_t'(s_tuser))
              OP_SCHEDULE: begin
                if (total == CW'(CAPACITY)) begin
                  res_kind <= KIND_FULL;
                  state <= S_EMIT;
                end else if (free_fill != '0) begin
                  state <= S_FREE;
                end else begin
                  id_ctr <= id_ctr + IDW'(1);
                  new_id <= id_ctr + IDW'(1);
                  state <= S_SCAN;
                end
              end
              OP_CANCEL: begin
                res_kind <= KIND_CANCEL_DONE;
                state <= (total == '0) ? S_EMIT : S_DATA;
              end
              OP_PROCESS: begin
                res_kind <= KIND_PROCESS_DONE;
                state <= (total == '0) ? S_EMIT : S_DATA;
              end
              default: ;
            endcase
          end
        end
        S_FREE: begin
          new_id <= free_rdata;
          free_head <= (free_head == AW'(CAPACITY - 1)) ? '0 : free_head + AW'(1);
          free_fill <= free_fill - CW'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          pos <= '0;
          idx <= total - CW'(1);
          state <= (total == '0) ? S_WRNEW : S_DATA;
        end
        S_DATA: begin
          case (rq_op)
            OP_SCHEDULE: begin
              if (sched_less) begin
                if (idx == '0) begin
                  pos <= '0;
                  state <= S_WRNEW;
                end else begin
                  idx <= idx - CW'(1);
                end
              end else begin
                pos <= AW'(idx + CW'(1));
                state <= S_WRNEW;
              end
            end
            OP_CANCEL: begin
              if (cid_hit) begin
                found <= 1'b1;
              end
              if (last_idx) begin
                if (found_now) begin
                  total <= total - CW'(1);
                  res_id <= rq_cid;
                end
                state <= S_EMIT;
              end else begin
                idx <= idx + CW'(1);
              end
            end
            OP_PROCESS: begin
              if (!proc_stall) begin
                if (pend) begin
                  m_tvalid <= 1'b1;
                  out_kind <= KIND_FIRED;
                  out_id <= pf_id;
                  out_tag <= pf_tag;
                  out_nh <= 1'b0;
                  out_fc <= '0;
                  out_head <= rd_time;
                  out_pend <= total - fcnt;
                  out_last <= 1'b0;
                end
                pend <= due;
                if (due) begin
                  pf_id <= rd_id;
                  pf_tag <= rd_tag;
                  fcnt <= fcnt + CW'(1);
                end
                if (proc_end) begin
                  if (due) begin
                    state <= S_FLUSH;
                  end else begin
                    total <= total - fcnt;
                    state <= S_EMIT;
                  end
                end else begin
                  idx <= idx + CW'(1);
                end
              end
            end
            default: state <= IDLE;
          endcase
        end
        S_FLUSH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            out_kind <= KIND_FIRED;
            out_id <= pf_id;
            out_tag <= pf_tag;
            out_nh <= 1'b0;
            out_fc <= '0;
            out_head <= TIME_MAX;
            out_pend <= total - fcnt;
            out_last <= 1'b0;
            pend <= 1'b0;
            total <= total - fcnt;
            state <= S_EMIT;
          end
        end
        S_WRNEW: begin
          total <= total + CW'(1);
          res_kind <= KIND_SCHEDULED;
          res_id <= new_id;
          res_nh <= (pos == '0) && notify;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            out_kind <= res_kind;
            out_id <= res_id;
            out_tag <= '0;
            out_nh <= res_nh;
            out_fc <= fcnt;
            out_head <= (total == '0) ? TIME_MAX : head_t;
            out_pend <= total;
            out_last <= 1'b1;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[OUT_BITS-1:0] = {out_pend, out_head, out_fc, out_nh, out_tag, out_id};
  end
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule

// ===== rtl/teq_checker.sv =====
// Port-level checker for the timed event queue, bound to the top level.
// Depends on teq_pkg and timed_event_queue.
`timescale 1ns / 1ps
module teq_checker
  import teq_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int TAG_BITS = 16
) (
  input logic clk,
  input logic rst,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((TIME_W+TAG_BITS+1+3*$clog2(CAPACITY+1)+7)/8)*8-1:0] m_tdata,
  input logic [2:0] m_tuser,
  input logic m_tlast
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int OUT_BITS = CW + TAG_BITS + 1 + CW + TIME_W + CW;

  logic [CW-1:0] pend_cnt;
  logic [TIME_W-1:0] head;
  assign pend_cnt = m_tdata[OUT_BITS-1 -: CW];
  assign head = m_tdata[OUT_BITS-CW-1 -: TIME_W];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_FULL |-> m_tdata[CW-1:0] == '0
      && pend_cnt == CW'(CAPACITY))
    else $error("full error with wrong id or count");

  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == KIND_FIRED) == !m_tlast)
    else $error("last flag disagrees with kind");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && pend_cnt == '0 |-> head == TIME_MAX)
    else $error("empty queue reports a head time");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pend_cnt <= CW'(CAPACITY))
    else $error("pending count above capacity");

endmodule

bind timed_event_queue teq_checker #(.CAPACITY(CAPACITY), .TAG_BITS(TAG_BITS)) u_teq_checker (.*);

// ===== sim/tb_timed_event_queue.sv =====
// Testbench for timed_event_queue: drives schedule, cancel and process requests with random
// idling and stalls, predicts every result with its own event store and free ID FIFO.
// Depends on rtl/teq_pkg.sv and rtl/timed_event_queue.sv.
`timescale 1ns / 1ps
module tb_timed_event_queue;
  import teq_pkg::*;

  localparam int CAP = 16;
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  id;
    logic [15:0] tag;
    logic        nh;
    logic [4:0]  fc;
    logic [63:0] head;
    logic [4:0]  pend;
    logic        last;
  } result_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_wdata = 0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [151:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [95:0] m_tdata;
  logic [2:0] m_tuser;
  logic m_tlast;

  timed_event_queue i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // predicted queue state
  logic signed [63:0] ev_time [CAP];
  logic [4:0] ev_id [CAP];
  logic [15:0] ev_tag [CAP];
  int ev_count = 0;
  logic [4:0] free_id [CAP];
  int free_rd = 0;
  int free_cnt = 0;
  logic [4:0] next_id = 0;
  logic notify = 0;

  result_t pending_results[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int cycles = 0;

  function automatic void push_result(kind_t k, logic [4:0] id, logic [15:0] tag, logic nh,
                                      logic [4:0] fc, logic last);
    result_t r;
    r.kind = k; r.id = id; r.tag = tag; r.nh = nh; r.fc = fc; r.last = last;
    r.head = ev_count ? ev_time[0] : TIME_MAX;
    r.pend = ev_count[4:0];
    pending_results.push_back(r);
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i < ev_count - 1; i++) begin
      ev_time[i] = ev_time[i+1]; ev_id[i] = ev_id[i+1]; ev_tag[i] = ev_tag[i+1];
    end
    ev_count--;
  endfunction

  function automatic void release_id(logic [4:0] id);
    if (free_cnt < CAP) begin
      free_id[(free_rd + free_cnt) % CAP] = id;
      free_cnt++;
    end
  endfunction

  function automatic void predict_queue(logic [1:0] op, logic signed [63:0] t, logic [15:0] tag,
                                        logic [4:0] cid, logic signed [63:0] now);
    logic [4:0] id;
    int pos;
    int fired;
    logic [4:0] done;
    case (op)
      OP_SCHEDULE: begin
        if (ev_count >= CAP) begin
          push_result(KIND_FULL, 0, 0, 0, 0, 1);
        end else begin
          if (free_cnt > 0) begin
            id = free_id[free_rd]; free_rd = (free_rd + 1) % CAP; free_cnt--;
          end else begin
            next_id++; id = next_id;
          end
          pos = ev_count;
          for (int i = 0; i < ev_count; i++)
            if (t < ev_time[i]) begin pos = i; break; end
          for (int i = ev_count; i > pos; i--) begin
            ev_time[i] = ev_time[i-1]; ev_id[i] = ev_id[i-1]; ev_tag[i] = ev_tag[i-1];
          end
          ev_time[pos] = t; ev_id[pos] = id; ev_tag[pos] = tag;
          ev_count++;
          push_result(KIND_SCHEDULED, id, 0, (pos == 0) && notify, 0, 1);
        end
      end
      OP_CANCEL: begin
        done = 0;
        for (int i = 0; i < ev_count; i++)
          if (ev_id[i] == cid) begin
            done = cid; drop_entry(i); release_id(cid); break;
          end
        push_result(KIND_CANCEL_DONE, done, 0, 0, 0, 1);
      end
      OP_PROCESS: begin
        fired = 0;
        while (ev_count > 0 && !(now < ev_time[0])) begin
          id = ev_id[0]; tag = ev_tag[0];
          drop_entry(0); release_id(id);
          push_result(KIND_FIRED, id, tag, 0, 0, 0);
          fired++;
        end
        push_result(KIND_PROCESS_DONE, 0, 0, 0, fired[4:0], 1);
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(logic [1:0] op, logic [63:0] t, logic [15:0] tag,
                              logic [4:0] cid, logic [63:0] now);
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {3'b0, now, cid, tag, t};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_queue(op, t, tag, cid, now);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_and_write_notify(logic v);
    s_tvalid <= 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    notify = v;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_time();
    case ($urandom_range(9))
      0: return rand64();
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return 64'h8000_0000_0000_0000;
      default: return 64'($signed($urandom_range(0, 60)) - 30);
    endcase
  endfunction

  task automatic test_directed();
    drain_and_write_notify(1);
    send_request(OP_SCHEDULE, 64'h7FFF_FFFF_FFFF_FFFF, 16'hFFFF, 5'd31, rand64());
    send_request(OP_SCHEDULE, 64'h8000_0000_0000_0000, 16'h0000, 5'd0, rand64());
    send_request(OP_SCHEDULE, 64'd5, 16'h1234, 5'd0, rand64());
    send_request(OP_SCHEDULE, 64'd5, 16'h5678, 5'd0, rand64());
    send_request(OP_CANCEL, rand64(), 16'hFFFF, 5'd0, rand64());
    send_request(OP_CANCEL, rand64(), 16'h0, 5'd31, rand64());
    send_request(OP_CANCEL, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 5'd2, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(OP_PROCESS, rand64(), 16'h0, 5'd0, 64'h8000_0000_0000_0000);
    send_request(OP_RESERVED, rand64(), 16'hFFFF, 5'd31, rand64());
    send_request(OP_PROCESS, rand64(), 16'h0, 5'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(OP_PROCESS, rand64(), 16'h0, 5'd0, 64'h7FFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < CAP + 1; i++)
      send_request(OP_SCHEDULE, pick_time(), 16'($urandom), 5'($urandom), rand64());
    send_request(OP_CANCEL, rand64(), 16'($urandom), 5'd16, rand64());
    send_request(OP_PROCESS, rand64(), 16'($urandom), 5'($urandom), 64'h7FFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_random(int n);
    logic [4:0] cid;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      cid = 5'($urandom);
      if (sel < 45) begin
        send_request(OP_SCHEDULE, pick_time(), 16'($urandom), cid, rand64());
      end else if (sel < 70) begin
        if (ev_count > 0 && $urandom_range(4) != 0) cid = ev_id[$urandom_range(ev_count - 1)];
        send_request(OP_CANCEL, rand64(), 16'($urandom), cid, rand64());
      end else if (sel < 95) begin
        send_request(OP_PROCESS, rand64(), 16'($urandom), cid, pick_time());
      end else begin
        send_request(OP_RESERVED, rand64(), 16'($urandom), cid, rand64());
      end
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else m_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = kind_t'(m_tuser);
      got.id = m_tdata[4:0];
      got.tag = m_tdata[20:5];
      got.nh = m_tdata[21];
      got.fc = m_tdata[26:22];
      got.head = m_tdata[90:27];
      got.pend = m_tdata[95:91];
      got.last = m_tlast;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got.kind != want.kind || got.id != want.id || got.tag != want.tag ||
            got.nh != want.nh || got.fc != want.fc || got.head != want.head ||
            got.pend != want.pend || got.last != want.last) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_full_queue();
    drain_and_write_notify(0);
    test_random(70);
    send_idle = 55;
    drain_and_write_notify(1);
    test_random(70);
    send_idle = 0;
    recv_stall = 55;
    drain_and_write_notify(0);
    test_random(70);
    send_idle = 27;
    recv_stall = 27;
    drain_and_write_notify(1);
    test_random(70);
    s_tvalid <= 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
